/* src/leftmost_free_stack_bank_top_defines.svh */
// Assertion macros for the leftmost free stack bank.
`ifndef LEFTMOST_FREE_STACK_BANK_TOP_DEFINES_SVH
`define LEFTMOST_FREE_STACK_BANK_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define LFSB_ASSERT(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) else $error(msg);
`define LFSB_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define LFSB_ASSERT(lbl, clk_s, rst_n_s, prop, msg)
`define LFSB_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif

`endif

/* src/lfsb_pkg.sv */
// Shared widths and codes of the leftmost free stack bank.
package lfsb_pkg;

	localparam int ACTION_W = 2;
	localparam int VALUE_W  = 32;
	localparam int INDEX_W  = 6;
	localparam int STATUS_W = 2;
	localparam int CAP_W    = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic [ACTION_W-1:0] ACT_PUSH   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_POP    = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_POP_AT = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

/* src/lfsb_item_if.sv */
// Valid/ready channel carrying one stack operation.
interface lfsb_item_if;
	logic                          valid;
	logic                          ready;
	logic [lfsb_pkg::ACTION_W-1:0] action;
	logic [lfsb_pkg::VALUE_W-1:0]  value;
	logic [lfsb_pkg::INDEX_W-1:0]  stack_index;

	modport source (output valid, action, value, stack_index, input ready);
	modport sink (input valid, action, value, stack_index, output ready);
endinterface

/* src/lfsb_result_if.sv */
// Valid/ready channel carrying one operation result.
interface lfsb_result_if;
	logic                          valid;
	logic                          ready;
	logic [lfsb_pkg::VALUE_W-1:0]  result_value;
	logic [lfsb_pkg::INDEX_W-1:0]  used_stack;
	logic [lfsb_pkg::STATUS_W-1:0] status;

	modport source (output valid, result_value, used_stack, status, input ready);
	modport sink (input valid, result_value, used_stack, status, output ready);
endinterface

/* src/leftmost_free_stack_bank_top.sv */
// Leftmost free stack bank: fill counts, search and plate memory.
//
// plates carries operations: push value onto the leftmost stack below the
// capacity, pop the rightmost non-empty stack, or pop a named stack.
// results returns one transaction per operation: popped value, stack used
// and status (ok, nothing to pop, bank full).
// cfg_we/cfg_wdata write the per-stack capacity (clamped to MAX_DEPTH);
// write it only while no operation is in flight.
// A result passes from the search stage through the read stage into the
// output register before it is offered; a stall can hold it in any stage.
// No operation is taken while the search stage holds one; the flag capture
// stage and the single-port plate memory access stage are used once per
// operation, and the next is taken once the fill counts are updated.
// Reset clears all fill counts at once and sets capacity to 16; the plate
// memory is not cleared, only slots below a fill count are ever read.
// A stalled result is held in the output register; a second waits in the
// read stage and a third in the search stage, after which plates.ready
// stays low.
`include "leftmost_free_stack_bank_top_defines.svh"

module leftmost_free_stack_bank_top #(
	parameter int NUM_STACKS = 64,
	parameter int MAX_DEPTH  = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [lfsb_pkg::CAP_W-1:0] cfg_wdata,
	lfsb_item_if.sink                  plates,
	lfsb_result_if.source              results
);

	localparam int KW    = $clog2(NUM_STACKS);
	localparam int CW    = $clog2(MAX_DEPTH + 1);
	localparam int EW    = (CW > lfsb_pkg::CAP_W) ? CW : lfsb_pkg::CAP_W;
	localparam int SW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int DEPTH = NUM_STACKS * MAX_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [lfsb_pkg::CAP_W-1:0] cap_q;
	logic [EW-1:0]              cap_ext;
	logic [EW-1:0]              cap_eff;

	logic [CW-1:0] fill_q [NUM_STACKS];
	logic [NUM_STACKS-1:0] nf_vec;
	logic [NUM_STACKS-1:0] ne_vec;

	logic                            s1_vld_q;
	logic [lfsb_pkg::ACTION_W-1:0]   action_s1;
	logic [lfsb_pkg::VALUE_W-1:0]    value_s1;
	logic [lfsb_pkg::INDEX_W-1:0]    index_s1;
	logic [NUM_STACKS-1:0]           nf_s1;
	logic [NUM_STACKS-1:0]           ne_s1;

	logic                            s2_vld_q;
	logic                            pop_s2;
	logic [lfsb_pkg::INDEX_W-1:0]    stack_s2;
	logic [lfsb_pkg::STATUS_W-1:0]   status_s2;

	logic                            out_vld_q;
	logic [lfsb_pkg::VALUE_W-1:0]    out_value_q;
	logic [lfsb_pkg::INDEX_W-1:0]    out_stack_q;
	logic [lfsb_pkg::STATUS_W-1:0]   out_status_q;

	logic [lfsb_pkg::VALUE_W-1:0] plate_mem [DEPTH];
	logic [lfsb_pkg::VALUE_W-1:0] rd_q;

	logic                          accept;
	logic                          out_free;
	logic                          s2_adv;
	logic                          s1_adv;
	logic [KW-1:0]                 left_nf;
	logic [KW-1:0]                 right_ne;
	logic [KW-1:0]                 sel_stk;
	logic                          sel_ok;
	logic                          sel_push;
	logic [lfsb_pkg::STATUS_W-1:0] sel_status;
	logic [CW-1:0]                 sel_cnt;
	logic [SW-1:0]                 slot;
	logic [AW-1:0]                 mem_addr;
	logic                          mem_we;
	logic                          mem_re;

	assign cap_ext = EW'(cap_q);
	assign cap_eff = (cap_ext > EW'(MAX_DEPTH)) ? EW'(MAX_DEPTH) : cap_ext;

	always_comb begin
		for (int s = 0; s < NUM_STACKS; s++) begin
			nf_vec[s] = EW'(fill_q[s]) < cap_eff;
			ne_vec[s] = fill_q[s] != '0;
		end
	end

	assign out_free     = !out_vld_q || results.ready;
	assign s2_adv       = s2_vld_q && out_free;
	assign s1_adv       = s1_vld_q && (!s2_vld_q || s2_adv);
	assign plates.ready = !s1_vld_q;
	assign accept       = plates.valid && plates.ready;

	// leftmost not-full and rightmost non-empty stacks
	always_comb begin
		left_nf  = '0;
		right_ne = '0;
		for (int s = NUM_STACKS - 1; s >= 0; s--) begin
			if (nf_s1[s]) begin
				left_nf = KW'(s);
			end
		end
		for (int s = 0; s < NUM_STACKS; s++) begin
			if (ne_s1[s]) begin
				right_ne = KW'(s);
			end
		end
	end

	always_comb begin
		sel_stk    = '0;
		sel_ok     = 1'b0;
		sel_push   = 1'b0;
		sel_status = lfsb_pkg::ST_EMPTY;
		unique case (action_s1)
			lfsb_pkg::ACT_PUSH: begin
				sel_push   = 1'b1;
				sel_ok     = |nf_s1;
				sel_stk    = left_nf;
				sel_status = sel_ok ? lfsb_pkg::ST_OK : lfsb_pkg::ST_FULL;
			end
			lfsb_pkg::ACT_POP: begin
				sel_ok     = |ne_s1;
				sel_stk    = right_ne;
				sel_status = sel_ok ? lfsb_pkg::ST_OK : lfsb_pkg::ST_EMPTY;
			end
			lfsb_pkg::ACT_POP_AT: begin
				sel_stk    = KW'(index_s1);
				sel_ok     = (32'(index_s1) < 32'(NUM_STACKS)) && ne_s1[KW'(index_s1)];
				sel_status = sel_ok ? lfsb_pkg::ST_OK : lfsb_pkg::ST_EMPTY;
			end
			default: begin
				sel_status = lfsb_pkg::ST_EMPTY;
			end
		endcase
	end

	assign sel_cnt  = fill_q[sel_stk];
	assign slot     = sel_push ? SW'(sel_cnt) : SW'(sel_cnt - 1'b1);
	assign mem_addr = AW'(sel_stk) * AW'(MAX_DEPTH) + AW'(slot);
	assign mem_we   = s1_adv && sel_ok && sel_push;
	assign mem_re   = s1_adv && sel_ok && !sel_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lfsb_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_STACKS; s++) begin
				fill_q[s] <= '0;
			end
		end else if (mem_we) begin
			fill_q[sel_stk] <= CW'(sel_cnt + 1'b1);
		end else if (mem_re) begin
			fill_q[sel_stk] <= CW'(sel_cnt - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			plate_mem[mem_addr] <= value_s1;
		end
		if (mem_re) begin
			rd_q <= plate_mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q  <= 1'b0;
			s2_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_vld_q <= 1'b1;
			end else if (s1_adv) begin
				s1_vld_q <= 1'b0;
			end
			if (s1_adv) begin
				s2_vld_q <= 1'b1;
			end else if (s2_adv) begin
				s2_vld_q <= 1'b0;
			end
			if (s2_adv) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= plates.action;
			value_s1  <= plates.value;
			index_s1  <= plates.stack_index;
			nf_s1     <= nf_vec;
			ne_s1     <= ne_vec;
		end
		if (s1_adv) begin
			pop_s2    <= sel_ok && !sel_push;
			stack_s2  <= sel_ok ? lfsb_pkg::INDEX_W'(sel_stk) : '0;
			status_s2 <= sel_status;
		end
		if (s2_adv) begin
			out_value_q  <= pop_s2 ? rd_q : '0;
			out_stack_q  <= stack_s2;
			out_status_q <= status_s2;
		end
	end

	assign results.valid        = out_vld_q;
	assign results.result_value = out_value_q;
	assign results.used_stack   = out_stack_q;
	assign results.status       = out_status_q;

	`LFSB_ASSERT(a_mem_one_port, clk, arst_n, !(mem_we && mem_re), "plate memory read and write together")
	`LFSB_ASSERT(a_push_not_full, clk, arst_n, mem_we |-> (EW'(sel_cnt) < cap_eff), "push onto a full stack")
	`LFSB_ASSERT(a_pop_not_empty, clk, arst_n, mem_re |-> (sel_cnt != '0), "pop from an empty stack")
	`LFSB_ASSERT(a_rd_held, clk, arst_n, (s2_vld_q && pop_s2 && !s2_adv) |=> $stable(rd_q), "popped plate lost during stall")
	`LFSB_ASSERT(a_no_back_to_back, clk, arst_n, accept |=> !plates.ready, "operation taken before fill counts updated")

endmodule

/* tb/leftmost_free_stack_bank_top_test.sv */
// Self-checking testbench for the leftmost free stack bank against a predictor.
`timescale 1ns / 100ps

module leftmost_free_stack_bank_top_test;

	localparam int BANK_STACKS    = 64;
	localparam int BANK_DEPTH     = 16;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 120;
	localparam int REPORT_LIMIT   = 10;

	localparam logic [lfsb_pkg::ACTION_W-1:0] ACT_NONE = 2'd3;

	typedef struct {
		logic [lfsb_pkg::ACTION_W-1:0] action;
		logic [lfsb_pkg::VALUE_W-1:0]  value;
		logic [lfsb_pkg::INDEX_W-1:0]  stack_index;
	} plate_op_t;

	typedef struct {
		logic [lfsb_pkg::VALUE_W-1:0]  value;
		logic [lfsb_pkg::INDEX_W-1:0]  stack;
		logic [lfsb_pkg::STATUS_W-1:0] status;
	} plate_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [lfsb_pkg::CAP_W-1:0] cfg_wdata;

	lfsb_item_if   plates_if();
	lfsb_result_if results_if();

	leftmost_free_stack_bank_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.plates   (plates_if),
		.results  (results_if)
	);

	always #2 clk = ~clk;

	// predictor state
	int                           stack_fill [BANK_STACKS];
	logic [lfsb_pkg::VALUE_W-1:0] plate_copy [BANK_STACKS][BANK_DEPTH];
	logic [lfsb_pkg::CAP_W-1:0]   capacity_setting = lfsb_pkg::CAP_RESET;

	plate_op_t     pending_ops[$];
	plate_result_t awaited_results[$];

	bit op_taken     = 1'b0;
	bit result_taken = 1'b0;
	bit drv_busy     = 1'b0;
	bit hold_req     = 1'b0;
	int src_gap_max  = 7;
	int sink_gap_max = 7;
	int gap_left     = 0;
	int stall_left   = 0;
	int hold_left    = 0;
	int fail_count   = 0;
	int quiet_cycles = 0;

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic bank_apply(input plate_op_t op);
		int            eff;
		int            s;
		bit            found;
		plate_result_t r;
		eff = (capacity_setting > BANK_DEPTH) ? BANK_DEPTH : int'(capacity_setting);
		found = 1'b0;
		r = '{value: '0, stack: '0, status: lfsb_pkg::ST_EMPTY};
		case (op.action)
			lfsb_pkg::ACT_PUSH: begin
				r.status = lfsb_pkg::ST_FULL;
				for (s = 0; s < BANK_STACKS && !found; s++) begin
					if (stack_fill[s] < eff) begin
						plate_copy[s][stack_fill[s]] = op.value;
						stack_fill[s]++;
						r.stack  = lfsb_pkg::INDEX_W'(s);
						r.status = lfsb_pkg::ST_OK;
						found    = 1'b1;
					end
				end
			end
			lfsb_pkg::ACT_POP: begin
				for (s = BANK_STACKS - 1; s >= 0 && !found; s--) begin
					if (stack_fill[s] != 0) begin
						stack_fill[s]--;
						r.value  = plate_copy[s][stack_fill[s]];
						r.stack  = lfsb_pkg::INDEX_W'(s);
						r.status = lfsb_pkg::ST_OK;
						found    = 1'b1;
					end
				end
			end
			lfsb_pkg::ACT_POP_AT: begin
				if (int'(op.stack_index) < BANK_STACKS && stack_fill[op.stack_index] != 0) begin
					stack_fill[op.stack_index]--;
					r.value  = plate_copy[op.stack_index][stack_fill[op.stack_index]];
					r.stack  = op.stack_index;
					r.status = lfsb_pkg::ST_OK;
				end
			end
			default: ;
		endcase
		awaited_results = {awaited_results, r};
	endtask

	// operation accept and prediction
	always @(posedge clk) begin
		if (arst_n && plates_if.valid && plates_if.ready) begin
			bank_apply('{action: plates_if.action, value: plates_if.value,
				stack_index: plates_if.stack_index});
			op_taken = 1'b1;
		end
	end

	// driver
	always @(negedge clk) begin
		plate_op_t op;
		if (op_taken) begin
			op_taken = 1'b0;
			drv_busy = 1'b0;
			gap_left = $urandom_range(0, src_gap_max);
		end
		if (!drv_busy) begin
			if (gap_left > 0) begin
				gap_left--;
				plates_if.valid <= 1'b0;
			end else if (pending_ops.size() != 0) begin
				op = pending_ops.pop_front();
				plates_if.action      <= op.action;
				plates_if.value       <= op.value;
				plates_if.stack_index <= op.stack_index;
				plates_if.valid       <= 1'b1;
				drv_busy = 1'b1;
			end else begin
				plates_if.valid <= 1'b0;
			end
		end
	end

	// monitor: compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		plate_result_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			result_taken = 1'b1;
			if (awaited_results.size() == 0) begin
				note_failure($sformatf("unexpected result %h stack %0d status %0d",
					results_if.result_value, results_if.used_stack, results_if.status));
			end else begin
				want = awaited_results.pop_front();
				if (results_if.result_value !== want.value || results_if.used_stack !== want.stack
						|| results_if.status !== want.status)
					note_failure($sformatf("expected %h/%0d/%0d got %h/%0d/%0d",
						want.value, want.stack, want.status, results_if.result_value,
						results_if.used_stack, results_if.status));
			end
		end
	end

	// result ready: per-transaction stalls plus an occasional long hold-off
	always @(negedge clk) begin
		if (result_taken) begin
			result_taken = 1'b0;
			stall_left = $urandom_range(0, sink_gap_max);
		end
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			results_if.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			results_if.ready <= 1'b0;
		end else begin
			results_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((plates_if.valid && plates_if.ready) || (results_if.valid && results_if.ready))
			quiet_cycles = 0;
		else if (arst_n)
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic queue_op(input logic [lfsb_pkg::ACTION_W-1:0] act,
			input logic [lfsb_pkg::VALUE_W-1:0] val, input logic [lfsb_pkg::INDEX_W-1:0] idx);
		plate_op_t op;
		op = '{action: act, value: val, stack_index: idx};
		pending_ops = {pending_ops, op};
	endtask

	task automatic queue_mix(input int count, input int push_pct, input int idx_span);
		int r;
		logic [lfsb_pkg::INDEX_W-1:0] idx;
		for (int i = 0; i < count; i++) begin
			r   = $urandom_range(0, 99);
			idx = $urandom_range(0, 1) ? lfsb_pkg::INDEX_W'($urandom_range(0, idx_span))
				: lfsb_pkg::INDEX_W'($urandom_range(0, BANK_STACKS - 1));
			if (r < push_pct)
				queue_op(lfsb_pkg::ACT_PUSH, $urandom, idx);
			else if (r < push_pct + (100 - push_pct) / 2)
				queue_op(lfsb_pkg::ACT_POP, $urandom, idx);
			else if (r < 97)
				queue_op(lfsb_pkg::ACT_POP_AT, $urandom, idx);
			else
				queue_op(ACT_NONE, $urandom, idx);
		end
	endtask

	task automatic settle();
		while (pending_ops.size() != 0 || drv_busy || awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(input logic [lfsb_pkg::CAP_W-1:0] cap);
		settle();
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(negedge clk);
		cfg_we <= 1'b0;
		capacity_setting = cap;
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		for (int s = 0; s < BANK_STACKS; s++)
			stack_fill[s] = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty pops, extremes of value and index, unused action
		queue_op(lfsb_pkg::ACT_POP, 32'h0, 6'd0);
		queue_op(lfsb_pkg::ACT_POP_AT, 32'h0, 6'd0);
		queue_op(lfsb_pkg::ACT_POP_AT, 32'hffff_ffff, 6'd63);
		queue_op(ACT_NONE, 32'h0, 6'd0);
		queue_op(lfsb_pkg::ACT_PUSH, 32'h0000_0000, 6'd0);
		queue_op(lfsb_pkg::ACT_PUSH, 32'hffff_ffff, 6'd63);
		queue_op(lfsb_pkg::ACT_PUSH, 32'ha5a5_a5a5, 6'd21);
		queue_op(lfsb_pkg::ACT_PUSH, 32'h5a5a_5a5a, 6'd42);
		queue_op(lfsb_pkg::ACT_POP_AT, 32'h0, 6'd63);
		queue_op(lfsb_pkg::ACT_POP_AT, 32'h0, 6'd0);
		queue_op(lfsb_pkg::ACT_POP, 32'h0, 6'd0);
		queue_op(lfsb_pkg::ACT_PUSH, 32'h8000_0000, 6'd0);
		queue_op(lfsb_pkg::ACT_PUSH, 32'h0000_0001, 6'd0);
		queue_op(ACT_NONE, 32'hffff_ffff, 6'd63);
		queue_op(lfsb_pkg::ACT_POP, 32'h0, 6'd0);
		queue_op(lfsb_pkg::ACT_POP, 32'h0, 6'd0);
		queue_op(lfsb_pkg::ACT_POP, 32'h0, 6'd0);
		queue_op(lfsb_pkg::ACT_POP, 32'h0, 6'd0);
		queue_op(lfsb_pkg::ACT_PUSH, 32'h1234_5678, 6'd0);
		queue_op(lfsb_pkg::ACT_PUSH, 32'hffff_0000, 6'd0);
		queue_op(lfsb_pkg::ACT_PUSH, 32'h0000_ffff, 6'd0);
		queue_op(lfsb_pkg::ACT_POP_AT, 32'h0, 6'd1);
		queue_op(lfsb_pkg::ACT_POP_AT, 32'h0, 6'd0);
		queue_op(lfsb_pkg::ACT_POP, 32'h0, 6'd0);
		queue_op(lfsb_pkg::ACT_POP_AT, 32'h0, 6'd0);

		// capacity 1: fill every stack, then overflow
		write_capacity(5'd1);
		repeat (BANK_STACKS + 2)
			queue_op(lfsb_pkg::ACT_PUSH, $urandom, lfsb_pkg::INDEX_W'($urandom));
		queue_mix(150, 40, 63);

		// capacity 0: every push dropped, pops still drain
		write_capacity(5'd0);
		queue_mix(60, 50, 63);

		// above the depth limit, no idling, with a long result hold-off
		write_capacity(5'd31);
		src_gap_max  = 0;
		sink_gap_max = 0;
		queue_mix(200, 70, 15);
		@(posedge clk);
		hold_req = 1'b1;
		settle();
		src_gap_max  = 7;
		sink_gap_max = 7;
		queue_mix(200, 70, 15);

		// lowered below the fill of the deep stacks
		write_capacity(5'd2);
		queue_mix(200, 50, 40);

		write_capacity(5'd16);
		queue_mix(400, 45, 20);

		repeat (3) begin
			write_capacity(lfsb_pkg::CAP_W'($urandom_range(1, 16)));
			src_gap_max  = $urandom_range(0, 7);
			sink_gap_max = $urandom_range(0, 7);
			queue_mix(150, 55, 63);
		end

		settle();
		repeat (8) @(posedge clk);
		if (awaited_results.size() != 0)
			note_failure($sformatf("%0d results never arrived", awaited_results.size()));
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
